// ===== hw/rtl/priority_task_scheduler_defines.svh =====
// Assertion macros shared by the priority task scheduler RTL.
// Used by pts_dp and priority_task_scheduler; no other dependencies.
`ifndef PRIORITY_TASK_SCHEDULER_DEFINES_SVH
`define PRIORITY_TASK_SCHEDULER_DEFINES_SVH
`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define PTS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("pts assertion failed");
// Same-cycle implication.
`define PTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pts implication failed");
// Next-cycle implication.
`define PTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pts next-cycle implication failed");
`else
`define PTS_ASSERT(label, clk, rst_n, prop)
`define PTS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PTS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/pts_pkg.sv =====
// Package for the priority task scheduler: default sizes, field widths,
// operation and status codes, and the controller/datapath interface structs.
// No dependencies.
`timescale 1ns / 1ps

package pts_pkg;

  // Default table geometry.
  localparam int unsigned TASK_SLOTS_DEF    = 8;
  localparam int unsigned PRIO_LEVELS_DEF   = 8;
  localparam int unsigned BLOCK_SOURCES_DEF = 16;

  // Fixed port field widths.
  localparam int unsigned OP_W       = 3;
  localparam int unsigned PRIO_IN_W  = 3;
  localparam int unsigned DUR_W      = 32;
  localparam int unsigned SRC_W      = 4;
  localparam int unsigned MASK_W     = 16;
  localparam int unsigned SLOT_OUT_W = 3;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned TICK_W     = 64;

  // Operation codes; the two unused codes are no-ops.
  typedef enum logic [OP_W-1:0] {
    OP_CREATE   = 3'd0,
    OP_SLEEP    = 3'd1,
    OP_WAIT     = 3'd2,
    OP_DESTROY  = 3'd3,
    OP_TICK     = 3'd4,
    OP_SCHEDULE = 3'd5
  } pts_op_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_FULL        = 2'd1,
    ST_NO_CURRENT  = 2'd2,
    ST_NO_RUNNABLE = 2'd3
  } pts_status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;       // latch a new transaction, restart the slot walk
    logic scan_step;     // advance the slot walk
    logic create_eval;   // test the walked slot for a free entry
    logic sched_eval;    // wake and rank the walked slot
    logic sched_commit;  // install the best candidate as current task
    logic simple_exec;   // sleep, wait, destroy, tick or no-op
    logic finish;        // register the result and strobe it
  } pts_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [OP_W-1:0] op_in;     // operation on the input port
    logic            scan_last; // walk is at the last slot
    logic            slot_free; // walked slot is not in use
  } pts_stat_t;

endpackage

// ===== hw/rtl/priority_task_scheduler.sv =====
// Top level of the priority task scheduler.
// Depends on pts_pkg, pts_ctrl, pts_dp and priority_task_scheduler_defines.svh.
//
//   Channel   Handshake                 Payload
//   request   start in, busy out        operation_i, task_priority_i,
//                                       sleep_duration_i, block_source_i,
//                                       blocked_sources_i
//   result    done_o strobe (1 cycle)   current_valid_o, current_slot_o,
//                                       new_slot_o, status_o
//
// Sleep, wait, destroy, tick and unused codes run in the single execute state.
// Create tests one slot flag per cycle until a free slot turns up or the table is full.
// Schedule walks the task table memories one slot per cycle and then
// commits the winner in state S_COMMIT.
// done_o pulses in the first cycle that busy is low again; a new start may be
// taken in that cycle.
// Reset clears the slot flags, counter and current task; no clearing pass.
// The receiver cannot stall the result.
`timescale 1ns / 1ps
`include "priority_task_scheduler_defines.svh"

module priority_task_scheduler import pts_pkg::*; #(
  parameter int unsigned TASK_SLOTS    = TASK_SLOTS_DEF,
  parameter int unsigned PRIO_LEVELS   = PRIO_LEVELS_DEF,
  parameter int unsigned BLOCK_SOURCES = BLOCK_SOURCES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [OP_W-1:0]       operation_i,
  input  logic [PRIO_IN_W-1:0]  task_priority_i,
  input  logic [DUR_W-1:0]      sleep_duration_i,
  input  logic [SRC_W-1:0]      block_source_i,
  input  logic [MASK_W-1:0]     blocked_sources_i,
  output logic                  done_o,
  output logic                  current_valid_o,
  output logic [SLOT_OUT_W-1:0] current_slot_o,
  output logic [SLOT_OUT_W-1:0] new_slot_o,
  output logic [STATUS_W-1:0]   status_o
);

  pts_cmd_t  cmd;
  pts_stat_t stat;

  // Sequencer for one transaction at a time.
  pts_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // Task table and scheduling datapath.
  pts_dp #(
    .TASK_SLOTS    (TASK_SLOTS),
    .PRIO_LEVELS   (PRIO_LEVELS),
    .BLOCK_SOURCES (BLOCK_SOURCES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .operation_i       (operation_i),
    .task_priority_i   (task_priority_i),
    .sleep_duration_i  (sleep_duration_i),
    .block_source_i    (block_source_i),
    .blocked_sources_i (blocked_sources_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .done_o            (done_o),
    .current_valid_o   (current_valid_o),
    .current_slot_o    (current_slot_o),
    .new_slot_o        (new_slot_o),
    .status_o          (status_o)
  );

  // An accepted transaction occupies the block; its result comes once it is free.
  `PTS_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)
  `PTS_ASSERT_IMP(a_done_idle, clk_i, rst_ni, done_o, !busy)
  `PTS_ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_o, !done_o)

endmodule

// ===== hw/rtl/pts_ctrl.sv =====
// Controller state machine of the priority task scheduler.
// Depends on pts_pkg for operation codes and the command/status structs.
`timescale 1ns / 1ps

module pts_ctrl import pts_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  pts_stat_t stat_i,
  output pts_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_CREATE,
    S_SCHED,
    S_COMMIT
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;

  // Next state and datapath commands.
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          case (stat_i.op_in)
            OP_CREATE:   state_d = S_CREATE;
            OP_SCHEDULE: state_d = S_SCHED;
            default:     state_d = S_EXEC;
          endcase
        end
      end
      S_EXEC: begin
        cmd_o.simple_exec = 1'b1;
        cmd_o.finish      = 1'b1;
        state_d           = S_IDLE;
      end
      S_CREATE: begin
        // Walk upward until a free slot turns up or the table is exhausted.
        cmd_o.create_eval = 1'b1;
        if (stat_i.slot_free || stat_i.scan_last) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_SCHED: begin
        cmd_o.sched_eval = 1'b1;
        cmd_o.scan_step  = 1'b1;
        if (stat_i.scan_last) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd_o.sched_commit = 1'b1;
        cmd_o.finish       = 1'b1;
        state_d            = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register and registered busy flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != S_IDLE);
    end
  end

  assign busy = busy_q;

endmodule

// ===== hw/rtl/pts_dp.sv =====
// Datapath of the priority task scheduler: task table memories, slot flags,
// tick counter, current-task registers, slot walk and result registers.
// Depends on pts_pkg and priority_task_scheduler_defines.svh.
`timescale 1ns / 1ps
`include "priority_task_scheduler_defines.svh"

module pts_dp import pts_pkg::*; #(
  parameter int unsigned TASK_SLOTS    = TASK_SLOTS_DEF,
  parameter int unsigned PRIO_LEVELS   = PRIO_LEVELS_DEF,
  parameter int unsigned BLOCK_SOURCES = BLOCK_SOURCES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [OP_W-1:0]       operation_i,
  input  logic [PRIO_IN_W-1:0]  task_priority_i,
  input  logic [DUR_W-1:0]      sleep_duration_i,
  input  logic [SRC_W-1:0]      block_source_i,
  input  logic [MASK_W-1:0]     blocked_sources_i,
  input  pts_cmd_t              cmd_i,
  output pts_stat_t             stat_o,
  output logic                  done_o,
  output logic                  current_valid_o,
  output logic [SLOT_OUT_W-1:0] current_slot_o,
  output logic [SLOT_OUT_W-1:0] new_slot_o,
  output logic [STATUS_W-1:0]   status_o
);

  localparam int unsigned SLOT_W = $clog2(TASK_SLOTS);
  localparam int unsigned PRIO_W = $clog2(PRIO_LEVELS);
  localparam int unsigned PEXT_W = PRIO_W + PRIO_IN_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TASK_SLOTS - 1);
  localparam logic [PRIO_W-1:0] TOP_PRIO  = PRIO_W'(PRIO_LEVELS - 1);

  typedef enum logic [1:0] {
    MODE_RUNNABLE = 2'd0,
    MODE_RUNNING  = 2'd1,
    MODE_SLEEPING = 2'd2,
    MODE_BLOCKED  = 2'd3
  } mode_e;

  // Latched transaction fields.
  logic [OP_W-1:0]      op_q;
  logic [PRIO_IN_W-1:0] prio_in_q;
  logic [DUR_W-1:0]     dur_q;
  logic [SRC_W-1:0]     src_q;
  logic [MASK_W-1:0]    mask_q;

  // Scheduler state held in flops.
  logic [TICK_W-1:0]     tick_q, tick_d;
  logic [SLOT_W-1:0]     run_slot_q, run_slot_d;
  logic                  run_valid_q, run_valid_d;
  logic [TASK_SLOTS-1:0] used_q, used_d;

  // Slot walk and best-candidate tracking.
  logic [SLOT_W-1:0] scan_idx_q, scan_idx_d;
  logic              have_q, have_d;
  logic [SLOT_W-1:0] best_q, best_d;
  logic [PRIO_W-1:0] best_prio_q, best_prio_d;

  // Task table memories, one registered read port at the walk address.
  mode_e             mode_mem [TASK_SLOTS];
  logic [PRIO_W-1:0] prio_mem [TASK_SLOTS];
  logic [SRC_W-1:0]  wsrc_mem [TASK_SLOTS];
  logic [TICK_W-1:0] wake_mem [TASK_SLOTS];
  mode_e             rd_mode_q;
  logic [PRIO_W-1:0] rd_prio_q;
  logic [SRC_W-1:0]  rd_wsrc_q;
  logic [TICK_W-1:0] rd_wake_q;

  // Memory write ports.
  logic              mode_we;
  logic [SLOT_W-1:0] mode_waddr;
  mode_e             mode_wdata;
  logic              prio_we;
  logic              wsrc_we;
  logic              wake_we;
  logic [TICK_W-1:0] wake_wdata;

  // Result assembly.
  logic [SLOT_W-1:0]          new_slot_d;
  pts_status_e                status_d;
  logic [SLOT_W+SLOT_OUT_W-1:0] cur_ext, new_ext;
  logic                       done_q;
  logic                       cur_valid_q;
  logic [SLOT_OUT_W-1:0]      cur_slot_q, new_slot_q;
  logic [STATUS_W-1:0]        status_q;

  // Per-slot evaluation terms.
  logic              slot_used;
  logic              wake_due;
  logic              src_blocking;
  logic              ready_now;
  logic              take;
  logic [PEXT_W-1:0] prio_ext;
  logic [PRIO_W-1:0] prio_sat;

  // Latch the transaction fields when it is accepted.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q      <= operation_i;
      prio_in_q <= task_priority_i;
      dur_q     <= sleep_duration_i;
      src_q     <= block_source_i;
      mask_q    <= blocked_sources_i;
    end
  end

  // Priority saturates to the top level.
  assign prio_ext = {{PRIO_W{1'b0}}, prio_in_q};
  assign prio_sat = (prio_ext >= PEXT_W'(PRIO_LEVELS)) ? TOP_PRIO : prio_ext[PRIO_W-1:0];

  // Wake and rank the walked slot; a running task counts as runnable again.
  assign slot_used    = used_q[scan_idx_q];
  assign wake_due     = (tick_q >= rd_wake_q);
  assign src_blocking = (32'(rd_wsrc_q) < BLOCK_SOURCES) && mask_q[rd_wsrc_q];

  always_comb begin
    case (rd_mode_q)
      MODE_RUNNABLE: ready_now = 1'b1;
      MODE_RUNNING:  ready_now = 1'b1;
      MODE_SLEEPING: ready_now = wake_due;
      MODE_BLOCKED:  ready_now = !src_blocking;
      default:       ready_now = 1'b0;
    endcase
  end

  assign take = cmd_i.sched_eval && slot_used && ready_now &&
                (!have_q || (rd_prio_q > best_prio_q));

  // Walk index; the memories read one slot ahead of the evaluation.
  always_comb begin
    scan_idx_d = scan_idx_q;
    if (cmd_i.capture) begin
      scan_idx_d = '0;
    end else if (cmd_i.scan_step && (scan_idx_q != LAST_SLOT)) begin
      scan_idx_d = scan_idx_q + SLOT_W'(1);
    end
  end

  // Best candidate so far; the strict compare keeps ties at the lower slot.
  always_comb begin
    have_d      = have_q;
    best_d      = best_q;
    best_prio_d = best_prio_q;
    if (cmd_i.capture) begin
      have_d = 1'b0;
    end else if (take) begin
      have_d      = 1'b1;
      best_d      = scan_idx_q;
      best_prio_d = rd_prio_q;
    end
  end

  // Table updates, counter, current task and result codes.
  always_comb begin
    tick_d      = tick_q;
    run_slot_d  = run_slot_q;
    run_valid_d = run_valid_q;
    used_d      = used_q;
    new_slot_d  = '0;
    status_d    = ST_OK;
    mode_we     = 1'b0;
    mode_waddr  = run_slot_q;
    mode_wdata  = MODE_RUNNABLE;
    prio_we     = 1'b0;
    wsrc_we     = 1'b0;
    wake_we     = 1'b0;
    wake_wdata  = tick_q + TICK_W'(dur_q);

    if (cmd_i.simple_exec) begin
      case (op_q)
        OP_SLEEP: begin
          if (!run_valid_q) begin
            status_d = ST_NO_CURRENT;
          end else begin
            wake_we    = 1'b1;
            mode_we    = 1'b1;
            mode_wdata = MODE_SLEEPING;
          end
        end
        OP_WAIT: begin
          if (!run_valid_q) begin
            status_d = ST_NO_CURRENT;
          end else begin
            wsrc_we    = 1'b1;
            mode_we    = 1'b1;
            mode_wdata = MODE_BLOCKED;
          end
        end
        OP_DESTROY: begin
          if (!run_valid_q) begin
            status_d = ST_NO_CURRENT;
          end else begin
            used_d[run_slot_q] = 1'b0;
            run_valid_d        = 1'b0;
            run_slot_d         = '0;
          end
        end
        OP_TICK: begin
          tick_d = tick_q + TICK_W'(1);
        end
        default: begin
        end
      endcase
    end

    if (cmd_i.create_eval) begin
      if (!slot_used) begin
        used_d[scan_idx_q] = 1'b1;
        mode_we            = 1'b1;
        mode_waddr         = scan_idx_q;
        mode_wdata         = MODE_RUNNABLE;
        prio_we            = 1'b1;
        new_slot_d         = scan_idx_q;
      end else if (scan_idx_q == LAST_SLOT) begin
        status_d = ST_FULL;
      end
    end

    // Woken or preempted tasks go back to runnable.
    if (cmd_i.sched_eval && slot_used && ready_now && (rd_mode_q != MODE_RUNNABLE)) begin
      mode_we    = 1'b1;
      mode_waddr = scan_idx_q;
      mode_wdata = MODE_RUNNABLE;
    end

    if (cmd_i.sched_commit) begin
      if (have_q) begin
        mode_we     = 1'b1;
        mode_waddr  = best_q;
        mode_wdata  = MODE_RUNNING;
        run_valid_d = 1'b1;
        run_slot_d  = best_q;
      end else begin
        run_valid_d = 1'b0;
        run_slot_d  = '0;
        status_d    = ST_NO_RUNNABLE;
      end
    end
  end

  // Control state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q      <= '0;
      run_slot_q  <= '0;
      run_valid_q <= 1'b0;
      used_q      <= '0;
      scan_idx_q  <= '0;
      have_q      <= 1'b0;
      best_q      <= '0;
      best_prio_q <= '0;
      done_q      <= 1'b0;
    end else begin
      tick_q      <= tick_d;
      run_slot_q  <= run_slot_d;
      run_valid_q <= run_valid_d;
      used_q      <= used_d;
      scan_idx_q  <= scan_idx_d;
      have_q      <= have_d;
      best_q      <= best_d;
      best_prio_q <= best_prio_d;
      done_q      <= cmd_i.finish;
    end
  end

  // Task table writes and registered reads.
  always_ff @(posedge clk_i) begin
    if (mode_we) begin
      mode_mem[mode_waddr] <= mode_wdata;
    end
    if (prio_we) begin
      prio_mem[scan_idx_q] <= prio_sat;
    end
    if (wsrc_we) begin
      wsrc_mem[run_slot_q] <= src_q;
    end
    if (wake_we) begin
      wake_mem[run_slot_q] <= wake_wdata;
    end
    rd_mode_q <= mode_mem[scan_idx_d];
    rd_prio_q <= prio_mem[scan_idx_d];
    rd_wsrc_q <= wsrc_mem[scan_idx_d];
    rd_wake_q <= wake_mem[scan_idx_d];
  end

  // Result registers; slot numbers carry their low bits only.
  assign cur_ext = {{SLOT_OUT_W{1'b0}}, run_slot_d};
  assign new_ext = {{SLOT_OUT_W{1'b0}}, new_slot_d};

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      cur_valid_q <= run_valid_d;
      cur_slot_q  <= cur_ext[SLOT_OUT_W-1:0];
      new_slot_q  <= new_ext[SLOT_OUT_W-1:0];
      status_q    <= status_d;
    end
  end

  assign done_o          = done_q;
  assign current_valid_o = cur_valid_q;
  assign current_slot_o  = cur_slot_q;
  assign new_slot_o      = new_slot_q;
  assign status_o        = status_q;

  assign stat_o.op_in     = operation_i;
  assign stat_o.scan_last = (scan_idx_q == LAST_SLOT);
  assign stat_o.slot_free = !slot_used;

  // The current task always occupies a slot, and an idle pointer reads zero.
  `PTS_ASSERT_IMP(a_cur_slot_used, clk_i, rst_ni, run_valid_q, used_q[run_slot_q])
  `PTS_ASSERT_IMP(a_idle_slot_zero, clk_i, rst_ni, !run_valid_q, run_slot_q == '0)
  `PTS_ASSERT_NEXT(a_create_claims, clk_i, rst_ni, cmd_i.create_eval && !slot_used, used_q[$past(scan_idx_q)])

endmodule
